### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define QALU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define QALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`QALU_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define QALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	`QALU_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### hw/rtl/qalu_pkg.sv
package qalu_pkg;

	// opcodes carried in s_tuser
	typedef enum logic [2:0] {
		CMD_MUL  = 3'd0,
		CMD_ROT  = 3'd1,
		CMD_CONJ = 3'd2,
		CMD_INV  = 3'd3,
		CMD_NORM = 3'd4,
		CMD_DOT  = 3'd5
	} cmd_t;

	// square root operates on a value normalized below 2^126
	localparam int SQRT_IN_BITS = 126;
	localparam int ROOT_BITS    = 63;

	// Hamilton product: component k sums a[t] * q[TERM_J[k][t]]
	localparam logic [1:0] TERM_J [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

	// bit t set: term t is subtracted
	localparam logic [3:0] TERM_N [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

### hw/rtl/qalu_lane.sv
module qalu_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3:0][W-1:0]     p,
	input  logic [3:0][W-1:0]     q,
	input  logic [3:0]            neg,
	output logic [2*W+1:0]        raw,
	output logic [W-1:0]          res,
	output logic                  sat
);

	localparam int AW = 2*W+2;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (F-1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] prod_s1 [4];
	logic [3:0]            neg_s1;
	logic signed [AW-1:0]  acc;
	logic signed [AW-1:0]  rnd;
	logic                  fits;
	logic [AW-1:0]         raw_s2;
	logic [W-1:0]          res_s2;
	logic                  sat_s2;

	// four products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				prod_s1[t] <= $signed(p[t]) * $signed(q[t]);
			end
			neg_s1 <= neg;
		end
	end

	// signed sum, round half up, clip
	always_comb begin
		acc = '0;
		for (int t = 0; t < 4; t++) begin
			if (neg_s1[t]) begin
				acc = acc - AW'(prod_s1[t]);
			end else begin
				acc = acc + AW'(prod_s1[t]);
			end
		end
		rnd  = (acc + HALF) >>> F;
		fits = (&rnd[AW-1:W-1]) | ~(|rnd[AW-1:W-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s2 <= acc;
			res_s2 <= fits ? rnd[W-1:0] : (rnd[AW-1] ? MINV : MAXV);
			sat_s2 <= ~fits;
		end
	end

	assign raw = raw_s2;
	assign res = res_s2;
	assign sat = sat_s2;

endmodule

### hw/rtl/qalu_sqrt.sv
module qalu_sqrt #(
	parameter int XW = 126,
	parameter int RB = 63
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	output logic [RB-1:0] root
);

	logic [XW-1:0] rem_s  [1:RB];
	logic [RB-1:0] root_s [1:RB];

	// one root bit per stage, most significant first
	for (genvar k = 1; k <= RB; k++) begin : g_stage
		localparam int I = RB - k;
		logic [XW-1:0] prv_rem;
		logic [RB-1:0] prv_root;
		logic [XW-1:0] trial;
		logic          take;

		if (k == 1) begin : g_first
			assign prv_rem  = x;
			assign prv_root = '0;
		end else begin : g_next
			assign prv_rem  = rem_s[k-1];
			assign prv_root = root_s[k-1];
		end

		assign trial = (XW'(prv_root) << (I+1)) | (XW'(1) << (2*I));
		assign take  = prv_rem >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (prv_rem - trial) : prv_rem;
				root_s[k] <= take ? (prv_root | (RB'(1) << I)) : prv_root;
			end
		end
	end

	assign root = root_s[RB];

endmodule

### hw/rtl/qalu_div.sv
module qalu_div #(
	parameter int NW = 83,
	parameter int DW = 67,
	parameter int QB = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic          ovf
);

	localparam int CW = (NW > DW+QB) ? NW : DW+QB;

	logic [NW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];

	// entry: flag quotients that do not fit in QB bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QB);
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int J = QB - k;
		logic [CW-1:0] sub;
		logic          take;

		assign sub  = CW'(den_s[k-1]) << J;
		assign take = CW'(rem_s[k-1]) >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NW'(CW'(rem_s[k-1]) - sub) : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= take ? (quo_s[k-1] | (QB'(1) << J)) : quo_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

### hw/rtl/quaternion_alu.sv
// Fixed-point quaternion unit: product, vector rotation, conjugate, inverse,
// normalize and dot, all operands signed WORD_BITS wide with FRAC_BITS fraction.
// Slave channel: s_tuser holds the opcode, s_tdata the eight operand words.
// Master channel: m_tdata holds r_w..r_z, m_tuser the zero-magnitude and
// saturation flags. One request in gives exactly one result out, in order.
// Path: every opcode passes through the same pipeline from accept to m_tvalid.
// Most of its depth is the 63-stage square root followed by the WORD_BITS + 2
// stage divider used by inverse and normalize.
// Throughput: one request per cycle while s_tready is high; every opcode flows
// through the same fully pipelined lanes (four product lanes, three rotate
// lanes, four divider lanes) and the merge stage picks the result by opcode.
// Stall: an output register plus a skid register decouple the sides; when the
// skid register fills the whole pipeline freezes and s_tready drops, and it
// resumes as soon as m_tready takes the waiting result.
// Reset: arst_n clears every valid bit, including those of the output and skid
// registers; no result is in flight afterwards and s_tready is high.
module quaternion_alu import qalu_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [8*WORD_BITS-1:0] s_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [2:0]           s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [4*WORD_BITS-1:0] m_tdata,  // r_w, r_x, r_y, r_z
	output logic [1:0]           m_tuser   // zero_magnitude, saturated
);

`include "assert_macros.svh"

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int AW   = 2*W+2;
	localparam int SW   = 2*W+1;
	localparam int RB   = ROOT_BITS;
	localparam int XW   = SQRT_IN_BITS;
	localparam int QB   = W+1;
	localparam int DENW = (SW > RB) ? SW : RB;
	localparam int DW   = DENW+1;
	localparam int NNW  = (W+2*F > F+RB+2) ? W+2*F : F+RB+2;
	localparam int NW   = ((NNW > DENW) ? NNW : DENW) + 2;
	localparam int NCH  = (SW+7)/8;
	localparam int BLX  = $clog2(XW+1);
	localparam int GW   = $clog2(XW/2+1);
	localparam int SHMX = (2*F > F+XW/2) ? 2*F : F+XW/2;
	localparam int SHW  = $clog2(SHMX+1);
	localparam int XS   = 5;
	localparam int PS   = XS+RB+1;
	localparam int DS   = PS+QB+1;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam bit ONE_FITS = (F <= W-2);
	localparam logic [W-1:0] ONEV = ONE_FITS ? (W'(1) << F) : MAXV;

	typedef struct packed {
		cmd_t               cmd;
		logic [3:0][W-1:0]  a;
		logic [3:0][W-1:0]  r;
		logic               sat;
		logic [SW-1:0]      mag;
		logic [GW-1:0]      g;
	} side_t;

	typedef struct packed {
		logic [3:0][W-1:0]  r;
		logic               sat;
		logic               zero;
	} res_t;

	logic              en;
	logic              push;
	logic              take;
	cmd_t              cmd_in;
	logic [3:0][W-1:0] a_in;
	logic [3:0][W-1:0] b_in;

	logic [3:0][W-1:0] p1 [4];
	logic [3:0][W-1:0] q1 [4];
	logic [3:0]        n1 [4];
	logic [3:0][W-1:0] b1_res;
	logic [3:0]        b1_sat;
	logic [AW-1:0]     b1_raw0;

	logic [3:0][W-1:0] p2 [1:3];
	logic [3:0][W-1:0] q2 [1:3];
	logic [3:0]        n2 [1:3];
	logic [3:1][W-1:0] b2_res;
	logic [3:1]        b2_sat;

	logic              vld_s  [1:DS];
	side_t             side_s [1:DS];
	side_t             m3, m4, m5;

	logic [NCH*8-1:0]  magp;
	logic [NCH-1:0]    ch_nz_s3;
	logic [3:0]        ch_len_s3 [NCH];
	logic [3:0]        ch_len [NCH];
	logic [BLX-1:0]    bitlen;
	logic [BLX-1:0]    gdiff;
	logic [XW-1:0]     x_s5;
	logic [RB-1:0]     root;

	side_t             sp;
	logic [DENW-1:0]   den_p;
	logic [SHW-1:0]    sh_p;
	logic [W-1:0]      ua [4];
	logic [NW-1:0]     num_s69 [4];
	logic [DW-1:0]     den_s69;
	logic [QB-1:0]     quo [4];
	logic [3:0]        ovf;

	side_t             hd;
	res_t              fin;
	logic              neg_f;
	logic [W+1:0]      sv;
	logic              fits_f;
	res_t              out_q;
	res_t              skid_q;
	logic              out_v_q;
	logic              skid_v_q;

	// pipeline advances unless the skid register is holding a result
	assign en       = ~skid_v_q;
	assign s_tready = en;
	assign take     = out_v_q & m_tready;
	assign push     = en & vld_s[DS];

	// unpack the request
	assign cmd_in = cmd_t'(s_tuser);
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_in[i] = s_tdata[i*W +: W];
			b_in[i] = s_tdata[(4+i)*W +: W];
		end
	end

	// operand routing for the first bank of product lanes
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int t = 0; t < 4; t++) begin
				p1[k][t] = a_in[t];
				q1[k][t] = (cmd_in == CMD_ROT && TERM_J[k][t] == 2'd0) ? '0
				           : b_in[TERM_J[k][t]];
				n1[k][t] = TERM_N[k][t];
				if (k == 0 && cmd_in == CMD_DOT) begin
					q1[k][t] = b_in[t];
					n1[k][t] = 1'b0;
				end else if (k == 0 && (cmd_in == CMD_INV || cmd_in == CMD_NORM)) begin
					q1[k][t] = a_in[t];
					n1[k][t] = 1'b0;
				end
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank1
		if (k == 0) begin : g_raw
			qalu_lane #(.W(W), .F(F)) u_lane (
				.clk (clk), .en (en), .p (p1[k]), .q (q1[k]), .neg (n1[k]),
				.raw (b1_raw0), .res (b1_res[k]), .sat (b1_sat[k])
			);
		end else begin : g_noraw
			qalu_lane #(.W(W), .F(F)) u_lane (
				.clk (clk), .en (en), .p (p1[k]), .q (q1[k]), .neg (n1[k]),
				.raw (), .res (b1_res[k]), .sat (b1_sat[k])
			);
		end
	end

	// second bank: rotated vector t * conj(a)
	always_comb begin
		for (int k = 1; k < 4; k++) begin
			for (int t = 0; t < 4; t++) begin
				p2[k][t] = b1_res[t];
				q2[k][t] = side_s[2].a[TERM_J[k][t]];
				n2[k][t] = TERM_N[k][t] ^ (TERM_J[k][t] != 2'd0);
			end
		end
	end

	for (genvar k = 1; k < 4; k++) begin : g_bank2
		qalu_lane #(.W(W), .F(F)) u_lane (
			.clk (clk), .en (en), .p (p2[k]), .q (q2[k]), .neg (n2[k]),
			.raw (), .res (b2_res[k]), .sat (b2_sat[k])
		);
	end

	// sideband merges at stages 3, 4 and 5
	always_comb begin
		m3 = side_s[2];
		unique case (side_s[2].cmd) inside
			CMD_MUL: begin
				m3.r   = b1_res;
				m3.sat = |b1_sat;
			end
			CMD_ROT: begin
				m3.sat = |b1_sat;
			end
			CMD_DOT: begin
				m3.r    = '0;
				m3.r[0] = b1_res[0];
				m3.sat  = b1_sat[0];
			end
			CMD_INV, CMD_NORM: begin
				m3.mag = b1_raw0[SW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		m4   = side_s[3];
		m4.g = GW'(gdiff >> 1);
	end

	always_comb begin
		m5 = side_s[4];
		if (side_s[4].cmd == CMD_ROT) begin
			m5.r[0]   = '0;
			m5.r[3:1] = b2_res;
			m5.sat    = side_s[4].sat | (|b2_sat);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '{default: 1'b0};
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int s = 2; s <= DS; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	// sideband payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1].cmd <= cmd_in;
			side_s[1].a   <= a_in;
			side_s[1].r   <= '0;
			side_s[1].sat <= 1'b0;
			side_s[1].mag <= '0;
			side_s[1].g   <= '0;
			for (int s = 2; s <= DS; s++) begin
				if (s == 3) begin
					side_s[s] <= m3;
				end else if (s == 4) begin
					side_s[s] <= m4;
				end else if (s == 5) begin
					side_s[s] <= m5;
				end else begin
					side_s[s] <= side_s[s-1];
				end
			end
		end
	end

	// bit length of the squared magnitude: per-byte search, then byte pick
	assign magp = (NCH*8)'(b1_raw0[SW-1:0]);
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			ch_len[c] = 4'd0;
			for (int b = 0; b < 8; b++) begin
				if (magp[c*8+b]) begin
					ch_len[c] = 4'(b+1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCH; c++) begin
				ch_nz_s3[c]  <= |magp[c*8 +: 8];
				ch_len_s3[c] <= ch_len[c];
			end
		end
	end

	always_comb begin
		bitlen = '0;
		for (int c = 0; c < NCH; c++) begin
			if (ch_nz_s3[c]) begin
				bitlen = BLX'(c*8) + BLX'(ch_len_s3[c]);
			end
		end
		gdiff = BLX'(XW) - bitlen;
	end

	// scale by an even power of two before the root
	always_ff @(posedge clk) begin
		if (en) begin
			x_s5 <= XW'(side_s[4].mag) << {side_s[4].g, 1'b0};
		end
	end

	qalu_sqrt #(.XW(XW), .RB(RB)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (x_s5),
		.root (root)
	);

	// divider operands: numerator 2n + d, divisor 2d
	assign sp    = side_s[PS-1];
	assign den_p = (sp.cmd == CMD_NORM) ? DENW'(root) : DENW'(sp.mag);
	assign sh_p  = (sp.cmd == CMD_NORM) ? (SHW'(F) + SHW'(sp.g)) : SHW'(2*F);
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ua[i] = sp.a[i][W-1] ? (~sp.a[i] + 1'b1) : sp.a[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				num_s69[i] <= (NW'(NNW'(ua[i]) << sh_p) << 1) + NW'(den_p);
			end
			den_s69 <= DW'(den_p) << 1;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		qalu_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s69[i]),
			.den (den_s69),
			.quo (quo[i]),
			.ovf (ovf[i])
		);
	end

	// merge: pick the result by opcode
	assign hd = side_s[DS];
	always_comb begin
		fin    = '0;
		neg_f  = 1'b0;
		sv     = '0;
		fits_f = 1'b1;
		unique case (hd.cmd) inside
			CMD_MUL, CMD_ROT, CMD_DOT: begin
				fin.r   = hd.r;
				fin.sat = hd.sat;
			end
			CMD_CONJ: begin
				fin.r[0] = hd.a[0];
				for (int i = 1; i < 4; i++) begin
					if (hd.a[i] == MINV) begin
						fin.r[i] = MAXV;
						fin.sat  = 1'b1;
					end else begin
						fin.r[i] = ~hd.a[i] + 1'b1;
					end
				end
			end
			CMD_INV, CMD_NORM: begin
				if (hd.mag == '0) begin
					fin.zero = 1'b1;
					fin.r[0] = ONEV;
					fin.sat  = ~ONE_FITS;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (hd.cmd == CMD_INV && i > 0) begin
							neg_f = ~hd.a[i][W-1] & (|hd.a[i]);
						end else begin
							neg_f = hd.a[i][W-1];
						end
						sv     = neg_f ? ((W+2)'(0) - (W+2)'(quo[i])) : (W+2)'(quo[i]);
						fits_f = ~ovf[i] & ((&sv[W+1:W-1]) | ~(|sv[W+1:W-1]));
						fin.r[i] = fits_f ? sv[W-1:0] : (neg_f ? MINV : MAXV);
						if (!fits_f) begin
							fin.sat = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || take) begin
				out_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.r;
	assign m_tuser  = {out_q.sat, out_q.zero};

	`QALU_ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q, "skid full with output empty")
	`QALU_ASSERT_NXT(a_stall_to_skid, clk, arst_n, push && out_v_q && !m_tready, skid_v_q, "result dropped on stall")
	`QALU_ASSERT_IMP(a_zero_identity, clk, arst_n, out_v_q && out_q.zero, out_q.r[1] == '0 && out_q.r[2] == '0 && out_q.r[3] == '0, "zero magnitude without identity")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import qalu_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef wide_t quat_t [4];
	typedef logic [31:0] word4_t [4];

	// one expected result
	typedef struct {
		logic [31:0] r [4];
		bit          zero_mag;
		bit          sat;
	} qres_t;

	localparam wide_t WMAX = 128'sd2147483647;
	localparam wide_t WMIN = -128'sd2147483648;

	// predicts quaternion results and matches them against the block output
	class quat_scoreboard;
		qres_t pending_q [$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		// clip to 32-bit signed range
		function logic [31:0] clip(wide_t v, inout bit flag);
			if (v > WMAX) begin
				flag = 1;
				return WMAX[31:0];
			end
			if (v < WMIN) begin
				flag = 1;
				return WMIN[31:0];
			end
			return v[31:0];
		endfunction

		function wide_t round_q(wide_t acc);
			return (acc + 128'sd32768) >>> 16;
		endfunction

		// Hamilton product, each component rounded and clipped
		function void hamilton(quat_t p, quat_t q, output word4_t r, output bit f [4]);
			wide_t acc [4];
			acc[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
			acc[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
			acc[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
			acc[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
			for (int k = 0; k < 4; k++) begin
				f[k] = 0;
				r[k] = clip(round_q(acc[k]), f[k]);
			end
		endfunction

		function int bit_length(logic [127:0] v);
			int n;
			n = 0;
			while (v != 0) begin
				v = v >> 1;
				n++;
			end
			return n;
		endfunction

		function logic [127:0] int_sqrt(logic [127:0] n);
			logic [127:0] res, b, t;
			res = 0;
			b = 128'd1 << 124;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				t = res + b;
				if (n >= t) begin
					n = n - t;
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function qres_t predict(cmd_t cmd, logic [31:0] aw [4], logic [31:0] bw [4]);
			qres_t e;
			quat_t a, b, v, t, ac;
			word4_t tr, rr;
			bit f [4];
			wide_t s, den, num, q;
			logic [127:0] mag;
			int g, sh;
			bit neg;
			for (int i = 0; i < 4; i++) begin
				a[i] = wide_t'($signed(aw[i]));
				b[i] = wide_t'($signed(bw[i]));
				e.r[i] = '0;
			end
			e.zero_mag = 0;
			e.sat = 0;
			case (cmd)
				CMD_MUL: begin
					hamilton(a, b, rr, f);
					e.r = rr;
					e.sat = f[0] | f[1] | f[2] | f[3];
				end
				CMD_ROT: begin
					v[0] = 0;
					for (int i = 1; i < 4; i++) v[i] = b[i];
					hamilton(a, v, tr, f);
					e.sat = f[0] | f[1] | f[2] | f[3];
					for (int i = 0; i < 4; i++) t[i] = wide_t'($signed(tr[i]));
					ac[0] = a[0];
					for (int i = 1; i < 4; i++) ac[i] = -a[i];
					hamilton(t, ac, rr, f);
					e.sat = e.sat | f[1] | f[2] | f[3];
					e.r = rr;
					e.r[0] = '0;
				end
				CMD_CONJ: begin
					e.r[0] = aw[0];
					for (int i = 1; i < 4; i++) e.r[i] = clip(-a[i], e.sat);
				end
				CMD_INV, CMD_NORM: begin
					s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
					if (s == 0) begin
						// zero magnitude returns identity
						e.zero_mag = 1;
						e.r[0] = 32'h0001_0000;
					end else begin
						den = s;
						sh = 32;
						if (cmd == CMD_NORM) begin
							g = (126 - bit_length(s)) / 2;
							den = int_sqrt(s << (2*g));
							sh = 16 + g;
						end
						for (int i = 0; i < 4; i++) begin
							neg = (cmd == CMD_INV && i > 0) ? (a[i] > 0) : (a[i] < 0);
							mag = (a[i] < 0) ? -a[i] : a[i];
							num = mag << sh;
							q = ((num << 1) + den) / (den << 1);
							e.r[i] = clip(neg ? -q : q, e.sat);
						end
					end
				end
				CMD_DOT: begin
					s = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
					e.r[0] = clip(round_q(s), e.sat);
				end
				default: ;
			endcase
			return e;
		endfunction

		function void note_request(logic [2:0] cmd, logic [255:0] data);
			logic [31:0] aw [4], bw [4];
			for (int i = 0; i < 4; i++) begin
				aw[i] = data[32*i +: 32];
				bw[i] = data[32*(i+4) +: 32];
			end
			pending_q.push_back(predict(cmd_t'(cmd), aw, bw));
		endfunction

		function void check_result(logic [127:0] data, logic [1:0] flags);
			qres_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %h flags %b", $time, data, flags);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			for (int i = 0; i < 4; i++)
				if (data[32*i +: 32] !== e.r[i]) begin
					$display("%0t: r[%0d] expected %h actual %h", $time, i, e.r[i],
						data[32*i +: 32]);
					errors++;
				end
			if (flags[0] !== e.zero_mag) begin
				$display("%0t: zero_magnitude expected %b actual %b", $time, e.zero_mag,
					flags[0]);
				errors++;
			end
			if (flags[1] !== e.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, e.sat, flags[1]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	int send_idle;
	int recv_stall;
	quat_scoreboard sb;

	quaternion_alu i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// random receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	// send one request, with random idle cycles ahead of it
	task automatic send_request(logic [2:0] cmd, logic [31:0] a [4], logic [31:0] b [4]);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		for (int i = 0; i < 4; i++) begin
			s_tdata[32*i +: 32] <= a[i];
			s_tdata[32*(i+4) +: 32] <= b[i];
		end
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4, 5: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			6: return $signed($urandom()) >>> $urandom_range(20);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_fill(logic [2:0] cmd, logic [31:0] av, logic [31:0] bv);
		logic [31:0] a [4], b [4];
		for (int i = 0; i < 4; i++) begin
			a[i] = av;
			b[i] = bv;
		end
		send_request(cmd, a, b);
	endtask

	task automatic send_random();
		logic [31:0] a [4], b [4];
		logic [2:0] cmd;
		cmd = 3'($urandom_range(CMD_DOT));
		for (int i = 0; i < 4; i++) begin
			a[i] = pick_word();
			b[i] = pick_word();
		end
		// zero a now and then so inverse and normalize hit the identity case
		if ($urandom_range(15) == 0)
			for (int i = 0; i < 4; i++) a[i] = '0;
		send_request(cmd, a, b);
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		send_idle = 0;
		recv_stall = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every opcode at the extremes, zero magnitude, identity
		for (int c = CMD_MUL; c <= CMD_DOT; c++) begin
			send_fill(3'(c), 32'h8000_0000, 32'h7FFF_FFFF);
			send_fill(3'(c), 32'h7FFF_FFFF, 32'h8000_0000);
			send_fill(3'(c), 32'h0001_0000, 32'hFFFF_0000);
		end
		send_fill(CMD_INV, 32'h0, 32'h1234_5678);
		send_fill(CMD_NORM, 32'h0, 32'hFFFF_FFFF);
		send_fill(CMD_NORM, 32'h0000_0001, 32'h0);
		send_fill(CMD_INV, 32'h0000_0001, 32'h0);
		send_fill(CMD_CONJ, 32'h8000_0000, 32'h0);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1) ? 63 : (ph == 3) ? 34 : 0;
			recv_stall = (ph == 2) ? 63 : (ph == 3) ? 34 : 0;
			for (int n = 0; n < 113; n++) send_random();
		end
		s_tvalid <= 0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// overall run limit
	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
